// ===== hw/rtl/pds_pkg.sv =====
// ----------------------------------------------------------------------------
// pds_pkg
// shared widths, register indexes and the cell record of the divider chain
// ----------------------------------------------------------------------------
package pds_pkg;

  // quotient bits, one divider cell each
  localparam int unsigned QuoW = 8;
  // product width of a 16 bit target and an 8 bit reference divider
  localparam int unsigned TmW  = 24;
  // divisor 2*R
  localparam int unsigned DivW = 17;
  // partial remainder, below 256 * 2R
  localparam int unsigned RemW = DivW + QuoW;

  localparam logic [1:0]      SlotMax = 2'd3;
  localparam logic [1:0]      PostMax = 2'd3;
  localparam logic [QuoW-1:0] FbSat   = 8'hFF;

  typedef enum logic [1:0] {
    CFG_REF_DIVIDER = 2'd0,
    CFG_REF_FREQ    = 2'd1,
    CFG_MIN_FREQ    = 2'd2,
    CFG_MAX_FREQ    = 2'd3
  } cfg_idx_e;

  // fields that ride along the chain untouched
  typedef struct packed {
    logic       hi;
    logic       lo;
    logic [1:0] p;
    logic [7:0] new_post_div;
    logic [1:0] slot;
  } side_t;

  typedef struct packed {
    logic [RemW-1:0] rem;
    logic [DivW-1:0] dvs;
    logic [QuoW-1:0] quo;
    side_t           side;
  } cell_t;

endpackage

// ===== hw/rtl/pds_front.sv =====
// ----------------------------------------------------------------------------
// pds_front
// clamps the request, forms T*M, picks the post code and loads the divider
// ----------------------------------------------------------------------------
module pds_front import pds_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_i,
  input  logic [15:0] target_freq_i,
  input  logic [7:0]  clock_slot_i,
  input  logic [7:0]  old_post_div_i,
  input  logic [7:0]  ref_divider_i,
  input  logic [15:0] ref_freq_i,
  input  logic [15:0] min_freq_i,
  input  logic [15:0] max_freq_i,
  output logic        active_o,
  output logic        valid_o,
  output cell_t       cell_o
);

  // stage a: clamp and multiply
  logic [15:0]    t_lo, t_cl;
  logic [1:0]     slot_cl;
  logic [TmW-1:0] tm_d;

  logic           a_valid_q;
  logic [TmW-1:0] a_tm_q;
  logic [15:0]    a_r_q;
  logic [1:0]     a_slot_q;
  logic [7:0]     a_old_q;

  always_comb begin
    t_lo    = (target_freq_i < min_freq_i) ? min_freq_i : target_freq_i;
    t_cl    = (t_lo > max_freq_i) ? max_freq_i : t_lo;
    slot_cl = (clock_slot_i > 8'(SlotMax)) ? SlotMax : clock_slot_i[1:0];
    tm_d    = TmW'(t_cl) * TmW'(ref_divider_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= req_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i) begin
      a_tm_q   <= tm_d;
      a_r_q    <= ref_freq_i;
      a_slot_q <= slot_cl;
      a_old_q  <= old_post_div_i;
    end
  end

  // stage b: thresholds on Q via T*M against multiples of R
  logic [TmW-1:0]  r255;
  logic            hi, lo;
  logic [1:0]      p;
  logic [2:0]      sh;
  logic [TmW+3:0]  num;
  logic [7:0]      newb;
  cell_t           cell_d;
  logic            valid_q;
  cell_t           cell_q;

  always_comb begin
    r255 = {a_r_q, 8'd0} - TmW'(a_r_q);
    hi   = (a_r_q == 16'd0) || ({1'b0, a_tm_q} > {r255, 1'b0});
    lo   = 1'b0;
    if (hi) begin
      p = 2'd0;
    end else if (a_tm_q > r255) begin
      p = 2'd0;
    end else if ({a_tm_q, 1'b0} > {1'b0, r255}) begin
      p = 2'd1;
    end else if ({a_tm_q, 2'b0} > {2'b0, r255}) begin
      p = 2'd2;
    end else begin
      p  = PostMax;
      lo = a_tm_q < {3'd0, a_r_q, 5'd0};
    end
    // rounding: (T*M*2^P + R) / (2R)
    num  = ((TmW + 4)'(a_tm_q) << p) + (TmW + 4)'(a_r_q);
    sh   = {a_slot_q, 1'b0};
    newb = (a_old_q & ~(8'(PostMax) << sh)) | (8'(p) << sh);

    cell_d.rem               = num[RemW-1:0];
    cell_d.dvs               = {a_r_q, 1'b0};
    cell_d.quo               = '0;
    cell_d.side.hi           = hi;
    cell_d.side.lo           = lo;
    cell_d.side.p            = p;
    cell_d.side.new_post_div = newb;
    cell_d.side.slot         = a_slot_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_valid_q) begin
      cell_q <= cell_d;
    end
  end

  assign active_o = a_valid_q | valid_q;
  assign valid_o  = valid_q;
  assign cell_o   = cell_q;

endmodule

// ===== hw/rtl/pds_div_cell.sv =====
// ----------------------------------------------------------------------------
// pds_div_cell
// one restoring division step, settles one quotient bit per request
// ----------------------------------------------------------------------------
module pds_div_cell import pds_pkg::*; #(
  parameter int unsigned BitIdx = 0
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  cell_t cell_i,
  output logic  valid_o,
  output cell_t cell_o
);

  logic [RemW-1:0] step;
  logic            fits;
  cell_t           cell_d;
  logic            valid_q;
  cell_t           cell_q;

  always_comb begin
    step   = RemW'(cell_i.dvs) << BitIdx;
    fits   = cell_i.rem >= step;
    cell_d = cell_i;
    if (fits) begin
      cell_d.rem         = cell_i.rem - step;
      cell_d.quo[BitIdx] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      cell_q <= cell_d;
    end
  end

  assign valid_o = valid_q;
  assign cell_o  = cell_q;

endmodule

// ===== hw/rtl/pll_divider_select_unit.sv =====
// ----------------------------------------------------------------------------
// pll_divider_select_unit
// feedback and post divider selection for a programmable pixel clock pll
// ----------------------------------------------------------------------------
// usage
//   request channel: target_freq_i, clock_slot_i and old_post_div_i are taken
//   at a rising edge where start_i is high and busy_o is low. busy_o stays
//   low, so a new request may enter every cycle.
//   result channel: done_o marks one cycle in which feedback_div_o,
//   post_code_o, new_post_div_o, slot_used_o, q_high_o and q_low_o hold the
//   result; the receiver cannot hold it off.
//   path: the request edge loads the first front stage; the request then
//   passes the second front stage, eight divider cells and one output
//   register, which raises done_o.
//   throughput: one request per cycle, set by the cell chain where each
//   cell settles one quotient bit and hands its remainder on every cycle.
//   configuration: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
//   ready is high only while no request is in flight.
//   reset: registers return to M=1, R=1432, min=0, max=65535 and all
//   requests in flight are dropped.
// ----------------------------------------------------------------------------
module pll_divider_select_unit import pds_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request
  input  logic        start_i,
  output logic        busy_o,
  input  logic [15:0] target_freq_i,
  input  logic [7:0]  clock_slot_i,
  input  logic [7:0]  old_post_div_i,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // result
  output logic        done_o,
  output logic [7:0]  feedback_div_o,
  output logic [1:0]  post_code_o,
  output logic [7:0]  new_post_div_o,
  output logic [1:0]  slot_used_o,
  output logic        q_high_o,
  output logic        q_low_o
);

  // configuration registers
  logic [7:0]  ref_divider_q;
  logic [15:0] ref_freq_q;
  logic [15:0] min_freq_q;
  logic [15:0] max_freq_q;
  logic        cfg_we;

  assign cfg_we = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_divider_q <= 8'd1;
      ref_freq_q    <= 16'd1432;
      min_freq_q    <= 16'd0;
      max_freq_q    <= 16'hFFFF;
    end else if (cfg_we) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_REF_DIVIDER: ref_divider_q <= cfg_data_i[7:0];
        CFG_REF_FREQ:    ref_freq_q    <= cfg_data_i;
        CFG_MIN_FREQ:    min_freq_q    <= cfg_data_i;
        CFG_MAX_FREQ:    max_freq_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline never stalls
  assign busy_o = 1'b0;

  logic front_active;
  logic valid_c [QuoW+1];
  cell_t cell_c [QuoW+1];

  pds_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (start_i & ~busy_o),
    .target_freq_i  (target_freq_i),
    .clock_slot_i   (clock_slot_i),
    .old_post_div_i (old_post_div_i),
    .ref_divider_i  (ref_divider_q),
    .ref_freq_i     (ref_freq_q),
    .min_freq_i     (min_freq_q),
    .max_freq_i     (max_freq_q),
    .active_o       (front_active),
    .valid_o        (valid_c[0]),
    .cell_o         (cell_c[0])
  );

  // cell k settles quotient bit QuoW-1-k, most significant first
  for (genvar k = 0; k < QuoW; k++) begin : g_cell
    pds_div_cell #(
      .BitIdx (QuoW - 1 - k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_c[k]),
      .cell_i  (cell_c[k]),
      .valid_o (valid_c[k+1]),
      .cell_o  (cell_c[k+1])
    );
  end

  // chain occupancy, blocks configuration writes while anything is in flight
  logic [QuoW:0] chain_busy;
  for (genvar k = 0; k <= QuoW; k++) begin : g_busy
    assign chain_busy[k] = valid_c[k];
  end

  // output register, saturated feedback divider when Q overflowed
  logic       done_q;
  logic [7:0] feedback_div_q;
  logic [1:0] post_code_q;
  logic [7:0] new_post_div_q;
  logic [1:0] slot_used_q;
  logic       q_high_q;
  logic       q_low_q;
  side_t      last_side;

  assign last_side = cell_c[QuoW].side;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_c[QuoW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_c[QuoW]) begin
      feedback_div_q <= last_side.hi ? FbSat : cell_c[QuoW].quo;
      post_code_q    <= last_side.p;
      new_post_div_q <= last_side.new_post_div;
      slot_used_q    <= last_side.slot;
      q_high_q       <= last_side.hi;
      q_low_q        <= last_side.lo;
    end
  end

  assign cfg_ready_o    = ~(front_active | (|chain_busy) | done_q);
  assign done_o         = done_q;
  assign feedback_div_o = feedback_div_q;
  assign post_code_o    = post_code_q;
  assign new_post_div_o = new_post_div_q;
  assign slot_used_o    = slot_used_q;
  assign q_high_o       = q_high_q;
  assign q_low_o        = q_low_q;

`ifndef NO_ASSERTIONS
  // overflow forces the saturated divider with the fastest post code
  a_high_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && q_high_o |-> feedback_div_o == FbSat && post_code_o == 2'd0)
    else $error("overflowed Q not saturated");

  // a low Q only arises on the slowest post code
  a_low_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && q_low_o |-> post_code_o == PostMax && !q_high_o)
    else $error("low Q flag with wrong post code");

  // an idle configuration port means no result can still be on its way
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o |-> !done_o)
    else $error("result while pipeline reported empty");

  // the new register byte carries the post code in the slot's field
  a_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((new_post_div_o >> {slot_used_o, 1'b0}) & 8'h03) == 8'(post_code_o))
    else $error("slot field does not hold the post code");
`endif

endmodule
